// ===== hw/rtl/triangle_unit_normal_core_assert.svh =====
// Assertion macros for the triangle unit normal core.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TUN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TUN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TUN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TUN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/tun_pkg.sv =====
// Package: shared types and constants of the triangle unit normal core.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int EdgeW  = 26;  // edge magnitude after prescale, below 2^25, plus sign
    localparam int CrossW = 52;  // exact cross component magnitude bits
    localparam int CmagW  = 30;  // prescaled cross magnitude
    localparam int SumW   = 62;
    localparam int LenW   = 31;
endpackage

// ===== hw/rtl/tun_if.sv =====
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface tun_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tun_sqrt_stage.sv =====
// One stage of the pipelined integer square root (two radicand bits per stage).
`timescale 1ns / 1ps
module tun_sqrt_stage import tun_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic [SumW-1:0] i_rem,
    input  logic [LenW-1:0] i_root,
    output logic [SumW-1:0] o_rem,
    output logic [LenW-1:0] o_root
);
    localparam int Shift = 2 * (LenW - 1 - STEP);
    logic [SumW+1:0] w_trial;
    logic [SumW+1:0] w_rem;
    always_comb begin
        w_rem   = {2'b00, i_rem};
        // trial is (4*root + 1) at the weight of the remaining bit pairs
        w_trial = ({2'b00, i_root, 2'b01} << Shift);
        if (w_rem >= w_trial) begin
            o_rem  = SumW'(w_rem - w_trial);
            o_root = {i_root[LenW-2:0], 1'b1};
        end else begin
            o_rem  = i_rem;
            o_root = {i_root[LenW-2:0], 1'b0};
        end
    end
endmodule

// ===== hw/rtl/tun_front.sv =====
// Front end: edges, edge prescale, cross product, cross prescale, squared sum.
`timescale 1ns / 1ps
module tun_front import tun_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int IDX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IDX_BITS-1:0]   i_index,
    input  logic [9*COORD_BITS-1:0] i_coords,
    output logic                  o_valid,
    output logic [IDX_BITS-1:0]   o_index,
    output logic                  o_degen,
    output logic [2:0]            o_neg,
    output logic [3*CmagW-1:0]    o_mag,
    output logic [SumW-1:0]       o_sum
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = (DW > EdgeW) ? DW - EdgeW + 1 : 1;

    // stage 1: exact edges
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic [IDX_BITS-1:0]    r_i1, r_i2, r_i3, r_i4;
    logic signed [DW-1:0]   r_e [6];
    // stage 2: prescaled edges
    logic signed [EdgeW-1:0] r_p [6];
    // stage 3: exact cross products
    logic signed [CrossW-1:0] r_c [3];
    // stage 4: prescaled magnitudes
    logic [2:0]              r_neg;
    logic                    r_dg;
    logic [CmagW-1:0]        r_m [3];
    // stage 5: squares, summed at the output
    logic                    r_v5, r_dg5;
    logic [IDX_BITS-1:0]     r_i5;
    logic [2:0]              r_neg5;
    logic [CmagW-1:0]        r_m5 [3];
    logic [SumW-1:0]         r_sq [3];

    logic [DW-1:0]           w_emag [6];
    logic [DW-1:0]           w_emax;
    logic [SW-1:0]           w_es;
    logic [CrossW-1:0]       w_cmag [3];
    logic [CrossW-1:0]       w_cmax;
    logic [5:0]              w_cs;

    always_comb begin
        w_emax = '0;
        for (int k = 0; k < 6; k++) begin
            w_emag[k] = r_e[k][DW-1] ? DW'(-r_e[k]) : DW'(r_e[k]);
            if (w_emag[k] > w_emax) w_emax = w_emag[k];
        end
        w_es = '0;
        for (int s = SW - 1; s >= 1; s--) begin
            if ((w_emax >> s) < DW'(1 << 25) && (w_emax >> (s - 1)) >= DW'(1 << 25))
                w_es = SW'(s);
        end
        w_cmax = '0;
        for (int k = 0; k < 3; k++) begin
            w_cmag[k] = r_c[k][CrossW-1] ? CrossW'(-r_c[k]) : CrossW'(r_c[k]);
            if (w_cmag[k] > w_cmax) w_cmax = w_cmag[k];
        end
        w_cs = '0;
        for (int s = 22; s >= 1; s--) begin
            if ((w_cmax >> s) < CrossW'(1 << 30) && (w_cmax >> (s - 1)) >= CrossW'(1 << 30))
                w_cs = 6'(s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i1 <= i_index; r_i2 <= r_i1; r_i3 <= r_i2; r_i4 <= r_i3; r_i5 <= r_i4;
            for (int k = 0; k < 3; k++) begin
                r_e[k]   <= DW'(signed'(i_coords[k*COORD_BITS +: COORD_BITS]))
                          - DW'(signed'(i_coords[(3+k)*COORD_BITS +: COORD_BITS]));
                r_e[3+k] <= DW'(signed'(i_coords[(6+k)*COORD_BITS +: COORD_BITS]))
                          - DW'(signed'(i_coords[(3+k)*COORD_BITS +: COORD_BITS]));
            end
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= r_e[k][DW-1] ? -EdgeW'(w_emag[k] >> w_es) : EdgeW'(w_emag[k] >> w_es);
            end
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= CrossW'(r_p[3+(k+1)%3] * r_p[(k+2)%3])
                        - CrossW'(r_p[3+(k+2)%3] * r_p[(k+1)%3]);
            end
            r_dg <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= r_c[k][CrossW-1];
                r_m[k]   <= CmagW'(w_cmag[k] >> w_cs);
            end
            r_dg5 <= r_dg; r_neg5 <= r_neg;
            for (int k = 0; k < 3; k++) begin
                r_m5[k] <= r_m[k];
                r_sq[k] <= SumW'(r_m[k]) * SumW'(r_m[k]);
            end
        end
    end

    assign o_valid = r_v5;
    assign o_index = r_i5;
    assign o_degen = r_dg5;
    assign o_neg   = r_neg5;
    assign o_mag   = {r_m5[2], r_m5[1], r_m5[0]};
    assign o_sum   = r_sq[0] + r_sq[1] + r_sq[2];
endmodule

// ===== hw/rtl/tun_back.sv =====
// Back end: pipelined square root, restoring dividers, rounding and saturation.
`timescale 1ns / 1ps
module tun_back import tun_pkg::*; #(
    parameter int NORMAL_BITS = 16,
    parameter int IDX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IDX_BITS-1:0]   i_index,
    input  logic                  i_degen,
    input  logic [2:0]            i_neg,
    input  logic [3*CmagW-1:0]    i_mag,
    input  logic [SumW-1:0]       i_sum,
    output logic                  o_valid,
    output logic [IDX_BITS-1:0]   o_index,
    output logic                  o_degen,
    output logic [3*NORMAL_BITS-1:0] o_normal
);
    localparam int NW = CmagW + NORMAL_BITS + 1;   // numerator m*2^(F+1)+L
    localparam int DVW = LenW + 1;                  // divisor 2L
    localparam int QB = NORMAL_BITS + 1;            // quotient below 2^(F+2)
    localparam int SQ = LenW;
    localparam int DEPTH = SQ + QB;

    // square root pipeline
    logic [SumW-1:0] r_rem  [1:SQ];
    logic [LenW-1:0] r_root [1:SQ];
    logic [SumW-1:0] w_srem [SQ];
    logic [LenW-1:0] w_sroot[SQ];
    logic [SumW-1:0] w_rem  [SQ];
    logic [LenW-1:0] w_root [SQ];
    // side band, one per stage (magnitudes through the square root only)
    logic                 r_v   [1:DEPTH];
    logic [IDX_BITS-1:0]  r_idx [1:DEPTH];
    logic                 r_dg  [1:DEPTH];
    logic [2:0]           r_ng  [1:DEPTH];
    logic [CmagW-1:0]     r_m   [1:SQ][3];
    // divider pipeline (three lanes)
    logic [NW-1:0]   r_n   [1:QB][3];
    logic [DVW-1:0]  r_d   [1:QB];
    logic [QB-1:0]   r_q   [1:QB][3];
    logic [NW-1:0]   w_n   [QB][3];
    logic [DVW-1:0]  w_d   [QB];
    logic [QB-1:0]   w_q   [QB][3];

    genvar g;
    for (g = 0; g < SQ; g++) begin : g_sqrt
        tun_sqrt_stage #(.STEP(g)) u_stage (
            .i_rem(w_srem[g]), .i_root(w_sroot[g]), .o_rem(w_rem[g]), .o_root(w_root[g])
        );
    end

    always_comb begin
        w_srem[0] = i_sum; w_sroot[0] = '0;
        for (int s = 1; s < SQ; s++) begin
            w_srem[s] = r_rem[s]; w_sroot[s] = r_root[s];
        end
        for (int k = 0; k < 3; k++) begin
            w_n[0][k] = (NW'(r_m[SQ][k]) << NORMAL_BITS) + NW'(r_root[SQ]);
            w_q[0][k] = '0;
        end
        w_d[0] = {r_root[SQ], 1'b0};
        for (int s = 1; s < QB; s++) begin
            w_d[s] = r_d[s];
            for (int k = 0; k < 3; k++) begin
                w_n[s][k] = r_n[s][k]; w_q[s][k] = r_q[s][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= DEPTH; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= DEPTH; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[1] <= i_index; r_dg[1] <= i_degen; r_ng[1] <= i_neg;
            for (int s = 2; s <= DEPTH; s++) begin
                r_idx[s] <= r_idx[s-1]; r_dg[s] <= r_dg[s-1]; r_ng[s] <= r_ng[s-1];
            end
            for (int k = 0; k < 3; k++) r_m[1][k] <= i_mag[k*CmagW +: CmagW];
            for (int s = 1; s <= SQ; s++) begin
                r_rem[s] <= w_rem[s-1]; r_root[s] <= w_root[s-1];
            end
            for (int s = 2; s <= SQ; s++) begin
                for (int k = 0; k < 3; k++) r_m[s][k] <= r_m[s-1][k];
            end
            // restoring division, one quotient bit per stage, MSB first
            for (int s = 1; s <= QB; s++) begin
                r_d[s] <= w_d[s-1];
                for (int k = 0; k < 3; k++) begin
                    if ((w_n[s-1][k] >> (QB - s)) >= NW'(w_d[s-1])) begin
                        r_n[s][k] <= w_n[s-1][k] - (NW'(w_d[s-1]) << (QB - s));
                        r_q[s][k] <= {w_q[s-1][k][QB-2:0], 1'b1};
                    end else begin
                        r_n[s][k] <= w_n[s-1][k];
                        r_q[s][k] <= {w_q[s-1][k][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dg[DEPTH]) begin
                o_normal[k*NORMAL_BITS +: NORMAL_BITS] = '0;
            end else if (r_ng[DEPTH][k]) begin
                o_normal[k*NORMAL_BITS +: NORMAL_BITS] = NORMAL_BITS'(-r_q[QB][k]);
            end else if (r_q[QB][k][QB-1:NORMAL_BITS-1] != '0) begin
                o_normal[k*NORMAL_BITS +: NORMAL_BITS] = {1'b0, {(NORMAL_BITS-1){1'b1}}};
            end else begin
                o_normal[k*NORMAL_BITS +: NORMAL_BITS] = NORMAL_BITS'(r_q[QB][k]);
            end
        end
    end

    assign o_valid = r_v[DEPTH];
    assign o_index = r_idx[DEPTH];
    assign o_degen = r_dg[DEPTH];
endmodule

// ===== hw/rtl/tun_queue.sv =====
// Small FIFO that decouples the pipeline from the output handshake.
`timescale 1ns / 1ps
module tun_queue #(
    parameter int W = 8,
    parameter int DEPTH_LOG = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    tun_if.source        o_out,
    output logic [DEPTH_LOG:0] o_count
);
    localparam int Depth = 1 << DEPTH_LOG;
    logic [W-1:0]         r_mem [Depth];
    logic [DEPTH_LOG-1:0] r_wp, r_rp;
    logic [DEPTH_LOG:0]   r_cnt, r_mcnt;
    logic                 r_ov;
    logic [W-1:0]         r_od;
    logic                 w_pop, w_load, w_fetch, w_bypass, w_write;
    assign w_pop    = r_ov && o_out.ready;
    assign w_load   = !r_ov || w_pop;
    assign w_fetch  = w_load && (r_mcnt != '0);
    // go straight to the output register when the memory is empty
    assign w_bypass = w_load && (r_mcnt == '0) && i_push;
    assign w_write  = i_push && !w_bypass;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_mcnt <= '0; r_ov <= 1'b0;
        end else begin
            if (w_write) r_wp <= r_wp + 1'b1;
            if (w_fetch) r_rp <= r_rp + 1'b1;
            r_mcnt <= r_mcnt + (DEPTH_LOG+1)'(w_write) - (DEPTH_LOG+1)'(w_fetch);
            r_cnt <= r_cnt + (DEPTH_LOG+1)'(i_push) - (DEPTH_LOG+1)'(w_pop);
            if (w_load) r_ov <= w_fetch || w_bypass;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_write) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (w_fetch) r_od <= r_mem[r_rp];
        else if (w_bypass) r_od <= i_data;
    end
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
    assign o_count     = r_cnt;
endmodule

// ===== hw/rtl/triangle_unit_normal_core.sv =====
// Top level of the triangle unit normal core.
// One triangle is accepted per cycle while the pipeline is not held; a result is offered
// after the front end, the square root (one root bit per stage) and the restoring
// divider (one quotient bit per stage). The pipeline advances freely while the output
// queue has room for every item in flight; it holds when the queue could overflow.
`timescale 1ns / 1ps
`include "triangle_unit_normal_core_assert.svh"
module triangle_unit_normal_core import tun_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int NORMAL_BITS = 16,
    parameter int MAX_FACETS = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tun_if.sink   i_in,
    tun_if.source o_out
);
    localparam int IB = 16;
    localparam int FB = $clog2(MAX_FACETS);
    localparam int OW = IB + 3 * NORMAL_BITS + 1;
    localparam int Lat = 5 + LenW + NORMAL_BITS + 1;
    localparam int QLog = $clog2(Lat + 2) + 1;

    logic                   w_fv, w_bv, w_bdg, w_en;
    logic [IB-1:0]          w_idx, w_fi, w_bi;
    logic                   w_fdg;
    logic [2:0]             w_fng;
    logic [3*CmagW-1:0]     w_fm;
    logic [SumW-1:0]        w_fs;
    logic [3*NORMAL_BITS-1:0] w_nrm;
    logic [QLog:0]          w_cnt;

    // facet index masked to clog2(MAX_FACETS) bits
    always_comb begin
        w_idx = i_in.data[IB-1:0];
        if (FB < IB) w_idx = i_in.data[IB-1:0] & IB'((1 << FB) - 1);
    end

    // hold the pipeline only when in-flight items could overrun the queue
    assign w_en = (int'(w_cnt) + Lat + 1) <= (1 << QLog);
    assign i_in.ready = w_en;

    tun_front #(.COORD_BITS(COORD_BITS), .IDX_BITS(IB)) u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_in.valid && w_en), .i_index(w_idx),
        .i_coords(i_in.data[IB +: 9*COORD_BITS]),
        .o_valid(w_fv), .o_index(w_fi), .o_degen(w_fdg), .o_neg(w_fng),
        .o_mag(w_fm), .o_sum(w_fs)
    );

    tun_back #(.NORMAL_BITS(NORMAL_BITS), .IDX_BITS(IB)) u_back (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv), .i_index(w_fi), .i_degen(w_fdg),
        .i_neg(w_fng), .i_mag(w_fm), .i_sum(w_fs),
        .o_valid(w_bv), .o_index(w_bi), .o_degen(w_bdg), .o_normal(w_nrm)
    );

    tun_queue #(.W(OW), .DEPTH_LOG(QLog)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_bv && w_en),
        .i_data({w_bdg, w_nrm, w_bi}), .o_out(o_out), .o_count(w_cnt)
    );

    `TUN_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, int'(w_cnt) <= (1 << QLog))
    `TUN_ASSERT_NXT(a_hold_empty, i_clk, i_rst_n, w_cnt == '0 && !(w_bv && w_en), !o_out.valid)
    `TUN_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, w_bv && w_bdg, w_nrm == '0)
endmodule

// ===== tb/tb_triangle_unit_normal_core.sv =====
// Testbench for the triangle unit normal core: streams triangles and checks every normal.
`timescale 1ns / 1ps
module tb_triangle_unit_normal_core;
    import tun_pkg::*;

    localparam int InW  = 16 + 9 * 24;
    localparam int OutW = 16 + 3 * 16 + 1;
    localparam int NumRandom = 930;

    typedef struct packed {
        logic [15:0]      idx;
        logic [8:0][23:0] crd;   // crd[0] is v0_x ... crd[8] is v2_z
        logic             sync;  // wait for all normals before this one goes out
    } tri_t;

    typedef struct packed {
        logic        degen;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
        logic [15:0] idx;
    } nrm_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tun_if #(.W(InW))  tri_ch ();
    tun_if #(.W(OutW)) nrm_ch ();

    triangle_unit_normal_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (tri_ch.sink),
        .o_out  (nrm_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tri_t tri_pending[$];
    nrm_t nrm_expected[$];
    int   mismatches = 0;
    int   cycle = 0;
    bit   stim_done = 1'b0;

    always @(posedge i_clk) cycle <= cycle + 1;

    function automatic logic [InW-1:0] pack_tri(tri_t t);
        logic [InW-1:0] d;
        d[15:0] = t.idx;
        for (int i = 0; i < 9; i++) d[16+24*i +: 24] = t.crd[i];
        return d;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // shift all magnitudes right until the largest drops below the bound
    function automatic void shrink(ref longint v[6], input int n, input longint unsigned bound);
        longint unsigned mx;
        longint unsigned m;
        int s;
        mx = 0;
        s = 0;
        for (int i = 0; i < n; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
        while ((mx >> s) >= bound && s < 63) s++;
        for (int i = 0; i < n; i++) begin
            m = mag(v[i]) >> s;
            v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic nrm_t face_normal(tri_t t);
        nrm_t r;
        longint e[6];
        longint c[6];
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [15:0] comp[3];
        int a;
        int b;
        for (int i = 0; i < 3; i++) begin
            e[i]     = longint'($signed(t.crd[i])) - longint'($signed(t.crd[3+i]));
            e[3 + i] = longint'($signed(t.crd[6+i])) - longint'($signed(t.crd[3+i]));
        end
        shrink(e, 6, 64'd1 << 25);
        for (int i = 0; i < 6; i++) c[i] = 0;
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            c[i] = e[3+a] * e[b] - e[3+b] * e[a];
        end
        r.idx = t.idx;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.degen = 1'b1;
            return r;
        end
        shrink(c, 3, 64'd1 << 30);
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag(c[i]) * mag(c[i]);
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag(c[i]) << 16) + len) / (len << 1);
            if (c[i] < 0) begin
                comp[i] = 16'(-longint'(q));
            end else begin
                if (q > 32767) q = 32767;
                comp[i] = 16'(q);
            end
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        tri_t nxt;
        bit quiet;
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
            tri_ch.data  <= '0;
        end else begin
            if (tri_ch.valid && tri_ch.ready) begin
                nrm_expected.push_back(face_normal(tri_pending.pop_front()));
            end
            if (!tri_ch.valid || tri_ch.ready) begin
                quiet = cycle > 150 && cycle < 350;
                if (tri_pending.size() == 0) begin
                    tri_ch.valid <= 1'b0;
                end else begin
                    nxt = tri_pending[0];
                    // hold a sync item until the pipeline has drained
                    if (nxt.sync && (nrm_expected.size() != 0 ||
                                     (tri_ch.valid && tri_ch.ready))) begin
                        tri_ch.valid <= 1'b0;
                    end else if (!quiet && $urandom_range(99) < 9) begin
                        tri_ch.valid <= 1'b0;
                    end else begin
                        tri_ch.valid <= 1'b1;
                        tri_ch.data  <= pack_tri(nxt);
                    end
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nrm_ch.ready <= 1'b0;
        end else begin
            if (cycle == 600) hold_cnt <= 200;
            else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
            if (hold_cnt > 0 || cycle == 600) nrm_ch.ready <= 1'b0;
            else if (cycle > 150 && cycle < 350) nrm_ch.ready <= 1'b1;
            else nrm_ch.ready <= $urandom_range(99) >= 9;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        nrm_t got;
        nrm_t want;
        if (i_rst_n && nrm_ch.valid && nrm_ch.ready) begin
            got = nrm_ch.data;
            if (nrm_expected.size() == 0) begin
                report_mismatch("unexpected index", got.idx, 16'h0000);
            end else begin
                want = nrm_expected.pop_front();
                if (got.idx != want.idx) report_mismatch("index", got.idx, want.idx);
                if (got.nx != want.nx) report_mismatch("normal_x", got.nx, want.nx);
                if (got.ny != want.ny) report_mismatch("normal_y", got.ny, want.ny);
                if (got.nz != want.nz) report_mismatch("normal_z", got.nz, want.nz);
                if (got.degen != want.degen)
                    report_mismatch("degenerate", 16'(got.degen), 16'(want.degen));
            end
        end
    end

    function automatic tri_t make_tri(logic [15:0] idx, int p[9]);
        tri_t t;
        t.idx = idx;
        for (int i = 0; i < 9; i++) t.crd[i] = 24'(p[i]);
        t.sync = 1'b0;
        return t;
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        int p[9];
        int base;
        int kind;
        int span;
        kind = $urandom_range(99);
        t.idx = 16'($urandom);
        t.sync = 1'b0;
        if (kind < 40) begin
            for (int i = 0; i < 9; i++) t.crd[i] = 24'($urandom);
        end else if (kind < 90) begin
            // small triangle somewhere in space
            span = 1 << $urandom_range(16, 1);
            for (int i = 0; i < 3; i++) begin
                base = $signed(24'($urandom)) / 2;
                p[i]   = base + $urandom_range(span) - span / 2;
                p[3+i] = base + $urandom_range(span) - span / 2;
                p[6+i] = base + $urandom_range(span) - span / 2;
            end
            for (int i = 0; i < 9; i++) t.crd[i] = 24'(p[i]);
        end else begin
            // collinear: p2 = p1 + k*(p0 - p1)
            span = $urandom_range(3, 0) - 1;
            for (int i = 0; i < 3; i++) begin
                p[3+i] = $signed(24'($urandom)) / 4;
                p[i]   = p[3+i] + int'($urandom_range(4000)) - 2000;
                p[6+i] = p[3+i] + span * (p[i] - p[3+i]);
            end
            for (int i = 0; i < 9; i++) t.crd[i] = 24'(p[i]);
        end
        return t;
    endfunction

    initial begin
        tri_t t;
        int mx;
        int mn;
        mx = 8388607;
        mn = -8388608;
        tri_ch.valid = 1'b0;
        tri_ch.data  = '0;
        nrm_ch.ready = 1'b0;
        tri_pending.push_back(make_tri(16'h0000, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        tri_pending.push_back(make_tri(16'hffff, '{1, 0, 0, 0, 0, 0, 0, 1, 0}));
        tri_pending.push_back(make_tri(16'h0001, '{0, 1, 0, 0, 0, 0, 1, 0, 0}));
        tri_pending.push_back(make_tri(16'h0002, '{0, 1, 0, 0, 0, 0, 0, 0, 1}));
        tri_pending.push_back(make_tri(16'h0003, '{0, 0, 1, 0, 0, 0, 0, 1, 0}));
        tri_pending.push_back(make_tri(16'h0004, '{0, 0, 1, 0, 0, 0, 1, 0, 0}));
        tri_pending.push_back(make_tri(16'h0005, '{1, 0, 0, 0, 0, 0, 0, 0, 1}));
        tri_pending.push_back(make_tri(16'h8000, '{mx, mx, mx, mn, mn, mn, mx, mn, mx}));
        tri_pending.push_back(make_tri(16'h7fff, '{mn, mx, mn, mx, mn, mx, mn, mn, mx}));
        tri_pending.push_back(make_tri(16'h1234, '{mx, mn, mn, mn, mx, mx, mx, mx, mn}));
        tri_pending.push_back(make_tri(16'haaaa, '{mx, mx, mx, mx, mx, mx, mx, mx, mx}));
        tri_pending.push_back(make_tri(16'h5555, '{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
        tri_pending.push_back(make_tri(16'h0100, '{mx, 0, 0, mn, 0, 0, 0, mx, 0}));
        tri_pending.push_back(make_tri(16'h0101, '{2, 4, 6, 1, 2, 3, 3, 6, 9}));
        tri_pending.push_back(make_tri(16'h0102, '{1, 1, 0, 0, 0, 0, 1, 2, 0}));
        tri_pending.push_back(make_tri(16'h0103, '{mx, mx, 0, mn, mn, 0, 0, 0, 0}));
        tri_pending.push_back(make_tri(16'h0104, '{3, 0, 0, 0, 4, 0, 0, 0, 5}));
        for (int i = 0; i < NumRandom; i++) begin
            t = rand_tri();
            if (i == 300 || i == 700) t.sync = 1'b1;
            tri_pending.push_back(t);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (tri_pending.size() == 0);
        wait (nrm_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && nrm_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end
endmodule
